// ===== rtl/wrrt_pkg.sv =====
// Shared constants, codes and payload types of the weighted receiver table.
`timescale 1ns / 1ps
package wrrt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ID_BITS     = 16;
  localparam int FRAC_BITS   = 16;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDW   = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int W_W   = FRAC_BITS + 1;
  localparam int NUM_W = W_W + FRAC_BITS;
  localparam int SUM_W = (W_W + CNT_W > 17) ? (W_W + CNT_W) : 17;

  localparam logic [W_W-1:0] ONE = W_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    OP_ADD_EQUAL    = 3'd0,
    OP_ADD_WEIGHTED = 3'd1,
    OP_REMOVE       = 3'd2,
    OP_DRAW         = 3'd3,
    OP_VIEW         = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NONE      = 3'd3,
    ST_DUP       = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] receiver_id;
    logic [16:0] weight_in;
    logic [16:0] random_value;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] chosen_id;
    logic [16:0] weight_out;
    logic        last;
  } out_t;

endpackage

// ===== rtl/wrrt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module wrrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wrrt_div.sv =====
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module wrrt_div
  import wrrt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [W_W-1:0]   den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int DC_W = $clog2(NUM_W + 1);

  logic [DC_W-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [W_W-1:0]   rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [W_W-1:0]   den_q, den_d;
  logic [W_W:0]     rem_sh;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DC_W'(NUM_W);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      // The dividend shifts out of the top while quotient bits enter below.
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = W_W'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[W_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DC_W'(1);
      if (cnt_q == DC_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/weighted_random_receiver_table.sv =====
// Top level of the weighted random receiver table.
`timescale 1ns / 1ps
// Roulette-wheel receiver table: up to MAX_ENTRIES IDs with Q1.16 weights
// held in two RAMs with registered read data and walked by a sequencer,
// one item at a time. Each visited slot is read, then evaluated, and each
// result passes through the output register. An add does a full ID search
// then one rescale pass; add-equal first runs the shared serial divider and
// remove runs it once per remaining entry when the removed weight is below
// one. The input is ready only while the sequencer is idle; a finished
// result may wait in the output register while the next item is taken.
module weighted_random_receiver_table
  import wrrt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_EV, S_FIND_END, S_EQ_DIV, S_UPD_RD, S_UPD_EV,
    S_UPD_DIV, S_FIN, S_DRW_RD, S_DRW_EV, S_VIEW_RD, S_VIEW_EV, S_EMIT
  } state_e;

  state_e               state_q, ret_q;
  logic [IDX_W-1:0]     idx_q, slot_q;
  logic [2:0]           op_q;
  logic [IDW-1:0]       id_q;
  logic [W_W-1:0]       p_q, wnew_q, den_q;
  logic [16:0]          r_q;
  logic [SUM_W-1:0]     sum_q;
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]     count_q;
  out_t                 res_q, out_q;
  logic                 out_valid_q;

  logic                 out_free, idx_last, more_after, is_add, div_done, div_start;
  logic [IDX_W-1:0]     free_idx;
  logic [IDW-1:0]       id_rdata;
  logic [W_W-1:0]       wt_rdata, wt_wdata, div_den, sat_quot;
  logic [NUM_W-1:0]     div_num, div_quot;
  logic [2*W_W-1:0]     prod;
  logic [SUM_W-1:0]     sum_next;
  logic                 ram_re, wt_we, id_we;
  logic [IDX_W-1:0]     waddr;
  logic [W_W-1:0]       p_sat;

  assign out_free = !out_valid_q || out_ready_i;
  assign idx_last = idx_q == IDX_W'(MAX_ENTRIES - 1);
  assign is_add   = (op_q == OP_ADD_EQUAL) || (op_q == OP_ADD_WEIGHTED);
  assign prod     = wt_rdata * (ONE - p_q);
  assign sum_next = sum_q + SUM_W'(wt_rdata);
  assign sat_quot = (div_quot > NUM_W'(ONE)) ? ONE : div_quot[W_W-1:0];
  assign p_sat    = (in_data_i.weight_in > 17'(ONE)) ? ONE : W_W'(in_data_i.weight_in);

  always_comb begin
    free_idx   = '0;
    more_after = 1'b0;
    for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
      if (!valid_q[j]) begin
        free_idx = IDX_W'(j);
      end
    end
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (IDX_W'(j) > idx_q && valid_q[j]) begin
        more_after = 1'b1;
      end
    end
  end

  // RAM and divider control follows the sequencer state.
  always_comb begin
    ram_re    = 1'b0;
    wt_we     = 1'b0;
    id_we     = 1'b0;
    waddr     = idx_q;
    wt_wdata  = wnew_q;
    div_start = 1'b0;
    div_num   = {wt_rdata, FRAC_BITS'(0)};
    div_den   = den_q;
    case (state_q)
      S_FIND_RD, S_UPD_RD, S_DRW_RD, S_VIEW_RD: begin
        ram_re = valid_q[idx_q];
      end
      S_FIND_END: begin
        if (is_add && !(&valid_q) && op_q == OP_ADD_EQUAL) begin
          div_start = 1'b1;
          div_num   = NUM_W'(ONE);
          div_den   = W_W'(count_q) + W_W'(1);
        end
      end
      S_UPD_EV: begin
        if (op_q == OP_REMOVE) begin
          div_start = 1'b1;
        end else begin
          wt_we = 1'b1;
          if (op_q == OP_ADD_WEIGHTED) begin
            wt_wdata = W_W'(prod >> FRAC_BITS);
          end
        end
      end
      S_UPD_DIV: begin
        wt_we    = div_done;
        wt_wdata = sat_quot;
      end
      S_FIN: begin
        if (is_add) begin
          wt_we = 1'b1;
          id_we = 1'b1;
          waddr = slot_q;
        end
      end
      default: begin
      end
    endcase
  end

  wrrt_ram #(.WIDTH(IDW), .DEPTH(MAX_ENTRIES)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (waddr),
    .wdata_i (id_q),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (id_rdata)
  );

  wrrt_ram #(.WIDTH(W_W), .DEPTH(MAX_ENTRIES)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (waddr),
    .wdata_i (wt_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (wt_rdata)
  );

  wrrt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      // A result taken in the same cycle a new one loads is replaced below.
      if (out_ready_i && !(state_q == S_EMIT && out_free)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q  <= in_data_i.operation;
            id_q  <= IDW'(in_data_i.receiver_id);
            p_q   <= p_sat;
            r_q   <= in_data_i.random_value;
            idx_q <= '0;
            sum_q <= '0;
            case (in_data_i.operation)
              OP_ADD_EQUAL, OP_ADD_WEIGHTED, OP_REMOVE: begin
                state_q <= S_FIND_RD;
              end
              OP_DRAW: begin
                state_q <= S_DRW_RD;
              end
              OP_VIEW: begin
                if (valid_q == '0) begin
                  res_q   <= '{status: ST_NONE, chosen_id: '0, weight_out: '0, last: 1'b1};
                  ret_q   <= S_IDLE;
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_VIEW_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FIND_RD: begin
          if (valid_q[idx_q]) begin
            state_q <= S_FIND_EV;
          end else if (idx_last) begin
            state_q <= S_FIND_END;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_FIND_EV: begin
          if (id_rdata == id_q) begin
            slot_q <= idx_q;
            ret_q  <= S_IDLE;
            if (is_add) begin
              res_q   <= '{status: ST_DUP, chosen_id: '0, weight_out: '0, last: 1'b1};
              state_q <= S_EMIT;
            end else begin
              valid_q[idx_q] <= 1'b0;
              count_q        <= count_q - CNT_W'(1);
              if (wt_rdata < ONE) begin
                den_q   <= ONE - wt_rdata;
                idx_q   <= '0;
                state_q <= S_UPD_RD;
              end else begin
                res_q   <= '{status: ST_OK, chosen_id: '0, weight_out: '0, last: 1'b1};
                state_q <= S_EMIT;
              end
            end
          end else if (idx_last) begin
            state_q <= S_FIND_END;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= S_FIND_RD;
          end
        end
        S_FIND_END: begin
          ret_q <= S_IDLE;
          if (!is_add) begin
            res_q   <= '{status: ST_NOT_FOUND, chosen_id: '0, weight_out: '0, last: 1'b1};
            state_q <= S_EMIT;
          end else if (&valid_q) begin
            res_q   <= '{status: ST_FULL, chosen_id: '0, weight_out: '0, last: 1'b1};
            state_q <= S_EMIT;
          end else begin
            slot_q <= free_idx;
            idx_q  <= '0;
            if (op_q == OP_ADD_EQUAL) begin
              state_q <= S_EQ_DIV;
            end else begin
              wnew_q  <= p_q;
              state_q <= S_UPD_RD;
            end
          end
        end
        S_EQ_DIV: begin
          if (div_done) begin
            wnew_q  <= div_quot[W_W-1:0];
            state_q <= S_UPD_RD;
          end
        end
        S_UPD_RD: begin
          if (valid_q[idx_q]) begin
            state_q <= S_UPD_EV;
          end else if (idx_last) begin
            state_q <= S_FIN;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_UPD_EV, S_UPD_DIV: begin
          if (state_q == S_UPD_EV && op_q == OP_REMOVE) begin
            state_q <= S_UPD_DIV;
          end else if (state_q == S_UPD_EV || div_done) begin
            if (idx_last) begin
              state_q <= S_FIN;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= S_UPD_RD;
            end
          end
        end
        S_FIN: begin
          if (is_add) begin
            valid_q[slot_q] <= 1'b1;
            count_q         <= count_q + CNT_W'(1);
          end
          res_q   <= '{status: ST_OK, chosen_id: '0, weight_out: '0, last: 1'b1};
          ret_q   <= S_IDLE;
          state_q <= S_EMIT;
        end
        S_DRW_RD: begin
          if (valid_q[idx_q]) begin
            state_q <= S_DRW_EV;
          end else if (idx_last) begin
            res_q   <= '{status: ST_NONE, chosen_id: '0, weight_out: '0, last: 1'b1};
            ret_q   <= S_IDLE;
            state_q <= S_EMIT;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_DRW_EV: begin
          sum_q <= sum_next;
          ret_q <= S_IDLE;
          if (sum_next >= SUM_W'(r_q)) begin
            res_q   <= '{status: ST_OK, chosen_id: 16'(id_rdata),
                         weight_out: 17'(wt_rdata), last: 1'b1};
            state_q <= S_EMIT;
          end else if (idx_last) begin
            res_q   <= '{status: ST_NONE, chosen_id: '0, weight_out: '0, last: 1'b1};
            state_q <= S_EMIT;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= S_DRW_RD;
          end
        end
        S_VIEW_RD: begin
          if (valid_q[idx_q]) begin
            state_q <= S_VIEW_EV;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_VIEW_EV: begin
          res_q   <= '{status: ST_OK, chosen_id: 16'(id_rdata),
                       weight_out: 17'(wt_rdata), last: !more_after};
          state_q <= S_EMIT;
          if (more_after) begin
            ret_q <= S_VIEW_RD;
            idx_q <= idx_q + IDX_W'(1);
          end else begin
            ret_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ret_q;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/wrrt_checker.sv =====
// Port-level assertions for the weighted receiver table, bound to the top level.
`timescale 1ns / 1ps
module wrrt_checker
  import wrrt_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Any failure status is a single final result with no payload.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.last && out_data_o.chosen_id == '0 && out_data_o.weight_out == '0)
    else $error("failure result carries payload or is not last");

  // Weights never exceed one.
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.weight_out <= 17'(ONE))
    else $error("weight above one");

  // A known operation keeps the input closed on the following cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.operation <= 3'(OP_VIEW) |=> !in_ready_o)
    else $error("input reopened right after a known operation");

endmodule

bind weighted_random_receiver_table wrrt_checker u_wrrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
